/* rtl/masked_byte_signature_scan_unit_macros.svh */
// assertion macros shared by the checker of the signature scan unit
// no dependencies; clock and reset are passed in by the user
`ifndef MASKED_BYTE_SIGNATURE_SCAN_UNIT_MACROS_SVH
`define MASKED_BYTE_SIGNATURE_SCAN_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define MBSS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scan unit check failed");

// next-cycle implication, disabled while reset is low
`define MBSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scan unit check failed");

`endif

/* rtl/mbss_pkg.sv */
// shared constants, types and helpers of the masked byte signature scan unit
// no dependencies; imported by every rtl module of the block
package mbss_pkg;

	localparam int MAX_PATTERN = 16;
	localparam int DATA_W      = 8;
	localparam int LEN_W       = 5;
	localparam int CNT_W       = 32;
	localparam int ADDR_W      = 64;
	localparam int PDATA_W     = 64;
	localparam int PADDR_W     = 6;
	localparam int BYTE_SEL_W  = $clog2(PDATA_W / 8);
	localparam int WIN_IDX_W   = $clog2(MAX_PATTERN);
	localparam int PAT_W       = MAX_PATTERN * DATA_W;

	// register map, one 64-bit register every 8 bytes
	typedef enum logic [PADDR_W-BYTE_SEL_W-1:0] {
		REG_PATTERN_LEN   = 3'd0,
		REG_PATTERN_LOW   = 3'd1,
		REG_PATTERN_HIGH  = 3'd2,
		REG_MASK_LOW      = 3'd3,
		REG_MASK_HIGH     = 3'd4,
		REG_BASE_ADDRESS  = 3'd5
	} reg_idx_t;

	// configuration as seen by the datapath
	typedef struct packed {
		logic [LEN_W-1:0]  used_len;
		logic [PAT_W-1:0]  pattern;
		logic [PAT_W-1:0]  mask;
		logic [ADDR_W-1:0] base;
	} cfg_t;

	// per-cell control from the top level
	typedef struct packed {
		logic              shift;
		logic              used;
		logic [DATA_W-1:0] mask;
		logic [DATA_W-1:0] pattern;
	} cell_ctl_t;

	// zero length acts as one, anything above the window acts as the window
	function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] n);
		logic [LEN_W-1:0] r;
		r = n;
		if (n == '0) begin
			r = LEN_W'(1);
		end else if (n > LEN_W'(MAX_PATTERN)) begin
			r = LEN_W'(MAX_PATTERN);
		end
		return r;
	endfunction

endpackage

/* rtl/mbss_cell.sv */
// one window cell: holds one region byte and tests the byte shifting into it
// depends on mbss_pkg
module mbss_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mbss_pkg::cell_ctl_t           ctl,
	input  logic [mbss_pkg::DATA_W-1:0]   din,
	output logic [mbss_pkg::DATA_W-1:0]   dout,
	output logic                          hit
);
	import mbss_pkg::*;

	logic [DATA_W-1:0] byte_q;

	// stored byte moves one cell along on every processed word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (ctl.shift) begin
			byte_q <= din;
		end
	end

	// masked compare of the incoming byte; unused cells always agree
	assign hit  = !ctl.used || ((din & ctl.mask) == ctl.pattern);
	assign dout = byte_q;

endmodule

/* rtl/mbss_regs.sv */
// apb register file holding pattern, mask, length and base address
// depends on mbss_pkg
module mbss_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mbss_pkg::PADDR_W-1:0]  paddr,
	input  logic [mbss_pkg::PDATA_W-1:0]  pwdata,
	output logic [mbss_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output mbss_pkg::cfg_t                cfg
);
	import mbss_pkg::*;

	logic [LEN_W-1:0]   len_q;
	logic [63:0]        pat_lo_q;
	logic [63:0]        pat_hi_q;
	logic [63:0]        mask_lo_q;
	logic [63:0]        mask_hi_q;
	logic [ADDR_W-1:0]  base_q;
	logic               wr;
	reg_idx_t           idx;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite & pready;
	assign idx    = reg_idx_t'(paddr[PADDR_W-1:BYTE_SEL_W]);

	// register writes; unmapped indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= LEN_W'(1);
			pat_lo_q  <= '0;
			pat_hi_q  <= '0;
			mask_lo_q <= '0;
			mask_hi_q <= '0;
			base_q    <= '0;
		end else if (wr) begin
			case (idx)
				REG_PATTERN_LEN:  len_q     <= pwdata[LEN_W-1:0];
				REG_PATTERN_LOW:  pat_lo_q  <= pwdata;
				REG_PATTERN_HIGH: pat_hi_q  <= pwdata;
				REG_MASK_LOW:     mask_lo_q <= pwdata;
				REG_MASK_HIGH:    mask_hi_q <= pwdata;
				REG_BASE_ADDRESS: base_q    <= pwdata;
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			REG_PATTERN_LEN:  prdata = PDATA_W'(len_q);
			REG_PATTERN_LOW:  prdata = pat_lo_q;
			REG_PATTERN_HIGH: prdata = pat_hi_q;
			REG_MASK_LOW:     prdata = mask_lo_q;
			REG_MASK_HIGH:    prdata = mask_hi_q;
			REG_BASE_ADDRESS: prdata = base_q;
			default:          prdata = '0;
		endcase
	end

	// datapath view
	assign cfg.used_len = clamp_len(len_q);
	assign cfg.pattern  = {pat_hi_q, pat_lo_q};
	assign cfg.mask     = {mask_hi_q, mask_lo_q};
	assign cfg.base     = base_q;

endmodule

/* rtl/masked_byte_signature_scan_unit.sv */
// top level of the masked byte signature scan unit
// depends on mbss_pkg, mbss_regs and mbss_cell
//
// channel  | handshake                  | payload
// ---------+----------------------------+-------------------------------
// bytes    | byte_valid / byte_ready    | data_byte, last_byte
// results  | result_valid / result_ready| found, match_address
// config   | apb psel/penable/pready    | paddr, pwdata, prdata
//
// one byte word per cycle while byte_ready is high; the 16 window cells compare in parallel
// a result is registered in the s1 stage (compare), then in the output stage (add)
// byte_ready drops only while a result waits in both the s1 stage and the output
// arst_n clears the window, count, match flag and both result stages
module masked_byte_signature_scan_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          byte_valid,
	output logic                          byte_ready,
	input  logic [mbss_pkg::DATA_W-1:0]   data_byte,
	input  logic                          last_byte,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic                          found,
	output logic [mbss_pkg::ADDR_W-1:0]   match_address,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mbss_pkg::PADDR_W-1:0]  paddr,
	input  logic [mbss_pkg::PDATA_W-1:0]  pwdata,
	output logic [mbss_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import mbss_pkg::*;

	cfg_t               cfg;
	logic               accept;
	logic               active;
	logic               enough;
	logic               hit;
	logic               push;
	logic               advance;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   cnt_next;
	logic [CNT_W-1:0]   off;
	logic               reported_q;
	logic [DATA_W-1:0]  win [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] hits;
	logic               valid_s1;
	logic               found_s1;
	logic [CNT_W-1:0]   off_s1;
	logic               result_valid_q;
	logic               found_q;
	logic [ADDR_W-1:0]  match_address_q;

	mbss_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// handshake and byte processing enables
	assign advance    = valid_s1 & (!result_valid_q | result_ready);
	assign byte_ready = !valid_s1 | advance;
	assign accept     = byte_valid & byte_ready;
	assign active     = accept & !reported_q;

	// saturating byte count and match offset
	assign cnt_next = (cnt_q == '1) ? cnt_q : cnt_q + CNT_W'(1);
	assign enough   = cnt_next >= CNT_W'(cfg.used_len);
	assign off      = cnt_next - CNT_W'(cfg.used_len);

	// window cells; cell k checks pattern byte len-1-k
	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
		localparam logic [LEN_W-1:0] K = LEN_W'(k);
		logic [WIN_IDX_W-1:0] j;
		logic [DATA_W-1:0]    din;
		cell_ctl_t            ctl;

		assign j           = WIN_IDX_W'(cfg.used_len - LEN_W'(1) - K);
		assign din         = (k == 0) ? data_byte : win[(k == 0) ? 0 : k - 1];
		assign ctl.shift   = active;
		assign ctl.used    = K < cfg.used_len;
		assign ctl.mask    = cfg.mask[j*DATA_W +: DATA_W];
		assign ctl.pattern = cfg.pattern[j*DATA_W +: DATA_W];

		mbss_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.din    (din),
			.dout   (win[k]),
			.hit    (hits[k])
		);
	end

	assign hit  = active & enough & (&hits);
	assign push = hit | (active & last_byte);

	// region state: count and match flag, cleared by the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			reported_q <= 1'b0;
		end else if (accept) begin
			if (last_byte) begin
				cnt_q      <= '0;
				reported_q <= 1'b0;
			end else if (active) begin
				cnt_q <= cnt_next;
				if (hit) begin
					reported_q <= 1'b1;
				end
			end
		end
	end

	// s1 stage: result decided, offset held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (push) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			found_s1 <= hit;
			off_s1   <= off;
		end
	end

	// output stage: address add
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			found_q         <= found_s1;
			match_address_q <= found_s1 ? cfg.base + ADDR_W'(off_s1) : '0;
		end
	end

	assign result_valid  = result_valid_q;
	assign found         = found_q;
	assign match_address = match_address_q;

endmodule

/* rtl/mbss_checker.sv */
// port-level checker of the masked byte signature scan unit, bound to the top
// depends on mbss_pkg and masked_byte_signature_scan_unit_macros.svh
`include "masked_byte_signature_scan_unit_macros.svh"

module mbss_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          byte_valid,
	input  logic                          byte_ready,
	input  logic                          result_valid,
	input  logic                          result_ready,
	input  logic                          found,
	input  logic [mbss_pkg::ADDR_W-1:0]   match_address
);
	import mbss_pkg::*;

	// a stalled result word holds
	`MBSS_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(found) && $stable(match_address))

	// a miss always carries a zero address
	`MBSS_ASSERT_SAME(a_miss_zero, clk, arst_n, result_valid && !found, match_address == '0)

	// input stalls only while a result is waiting
	`MBSS_ASSERT_SAME(a_stall_cause, clk, arst_n, !byte_ready, result_valid)

	// a fresh result traces back through the s1 stage to an accepted byte
	`MBSS_ASSERT_SAME(a_result_origin, clk, arst_n, $rose(result_valid), $past(byte_valid && byte_ready, 2))

endmodule

bind masked_byte_signature_scan_unit mbss_checker u_mbss_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.byte_valid    (byte_valid),
	.byte_ready    (byte_ready),
	.result_valid  (result_valid),
	.result_ready  (result_ready),
	.found         (found),
	.match_address (match_address)
);

/* dv/masked_byte_signature_scan_unit_tb.sv */
// self-checking testbench of the masked byte signature scan unit
// depends on mbss_pkg and masked_byte_signature_scan_unit; predicts every result in a class
`timescale 1ns / 100ps

module masked_byte_signature_scan_unit_tb;
	import mbss_pkg::*;

	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_BYTES  = 1450;

	typedef struct {
		logic              found;
		logic [ADDR_W-1:0] addr;
	} scan_result_t;

	// byte-level model of the scan, plus the queue of results still owed
	class scan_scoreboard;
		logic [LEN_W-1:0]  len_reg;
		logic [PAT_W-1:0]  pattern_bytes;
		logic [PAT_W-1:0]  mask_bytes;
		logic [ADDR_W-1:0] base;
		logic [DATA_W-1:0] window[MAX_PATTERN];
		logic [CNT_W-1:0]  seen;
		logic              reported;
		scan_result_t      awaited_results[$];
		int                errors;
		int                checked;
		int                match_count;

		function new();
			len_reg       = LEN_W'(1);
			pattern_bytes = '0;
			mask_bytes    = '0;
			base          = '0;
			errors        = 0;
			checked       = 0;
			match_count   = 0;
			clear_region();
		endfunction

		function void clear_region();
			foreach (window[k]) window[k] = '0;
			seen     = '0;
			reported = 1'b0;
		endfunction

		// zero acts as one, anything past the window as the window
		function int eff_len();
			int n;
			n = int'(len_reg);
			if (n == 0) n = 1;
			if (n > MAX_PATTERN) n = MAX_PATTERN;
			return n;
		endfunction

		function void set_reg(reg_idx_t idx, logic [PDATA_W-1:0] v);
			case (idx)
				REG_PATTERN_LEN:  len_reg = v[LEN_W-1:0];
				REG_PATTERN_LOW:  pattern_bytes[63:0] = v;
				REG_PATTERN_HIGH: pattern_bytes[127:64] = v;
				REG_MASK_LOW:     mask_bytes[63:0] = v;
				REG_MASK_HIGH:    mask_bytes[127:64] = v;
				REG_BASE_ADDRESS: base = v;
				default: ;
			endcase
		endfunction

		function int pending();
			return awaited_results.size();
		endfunction

		// one accepted byte word: shift, count, test the newest position
		function void note_byte(logic [DATA_W-1:0] b, logic last);
			int           len;
			logic         hit;
			logic [7:0]   v;
			scan_result_t r;
			hit = 1'b0;
			if (!reported) begin
				len = eff_len();
				for (int k = MAX_PATTERN - 1; k > 0; k--) window[k] = window[k-1];
				window[0] = b;
				if (seen != '1) seen = seen + 1;
				if (seen >= CNT_W'(len)) begin
					hit = 1'b1;
					for (int j = 0; j < len; j++) begin
						v = window[len-1-j];
						if ((v & mask_bytes[8*j +: 8]) != pattern_bytes[8*j +: 8]) hit = 1'b0;
					end
					if (hit) begin
						r.found = 1'b1;
						r.addr  = base + ADDR_W'(seen - CNT_W'(len));
						awaited_results.push_back(r);
						reported = 1'b1;
						match_count++;
					end
				end
				if (last && !hit) begin
					r.found = 1'b0;
					r.addr  = '0;
					awaited_results.push_back(r);
				end
			end
			if (last) clear_region();
		endfunction

		function void check_result(logic f, logic [ADDR_W-1:0] a);
			scan_result_t e;
			checked++;
			if (awaited_results.size() == 0) begin
				$error("unexpected result: found=%0b match_address=%h", f, a);
				errors++;
				return;
			end
			e = awaited_results.pop_front();
			if (f !== e.found) begin
				$error("found: expected %0b, actual %0b", e.found, f);
				errors++;
			end
			if (a !== e.addr) begin
				$error("match_address: expected %h, actual %h", e.addr, a);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               byte_valid;
	logic               byte_ready;
	logic [DATA_W-1:0]  data_byte;
	logic               last_byte;
	logic               result_valid;
	logic               result_ready;
	logic               found;
	logic [ADDR_W-1:0]  match_address;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	scan_scoreboard     sb = new();
	logic [DATA_W-1:0]  region_q[$];
	logic               no_idle;
	int                 bytes_sent;
	int                 regions_sent;
	int                 settings;

	masked_byte_signature_scan_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.found        (found),
		.match_address(match_address),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// result side: random stalls except in the busy stretch
	always @(negedge clk) begin
		result_ready <= no_idle || ($urandom_range(99) >= 36);
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) sb.check_result(found, match_address);
	end

	// register write: setup, then access
	task automatic reg_write(input reg_idx_t idx, input logic [PDATA_W-1:0] v);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_reg(idx, v);
	endtask

	task automatic reg_bus_idle();
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		settings++;
	endtask

	task automatic write_all(input logic [LEN_W-1:0] len, input logic [PAT_W-1:0] pat,
			input logic [PAT_W-1:0] msk, input logic [ADDR_W-1:0] b);
		reg_write(REG_PATTERN_LEN, PDATA_W'(len));
		reg_write(REG_PATTERN_LOW, pat[63:0]);
		reg_write(REG_PATTERN_HIGH, pat[127:64]);
		reg_write(REG_MASK_LOW, msk[63:0]);
		reg_write(REG_MASK_HIGH, msk[127:64]);
		reg_write(REG_BASE_ADDRESS, b);
		reg_bus_idle();
	endtask

	// one byte word, with random idle cycles ahead of it
	task automatic send_byte(input logic [DATA_W-1:0] b, input logic l);
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < 36) begin
			byte_valid <= 1'b0;
			@(negedge clk);
		end
		byte_valid <= 1'b1;
		data_byte  <= b;
		last_byte  <= l;
		@(posedge clk);
		while (!byte_ready) @(posedge clk);
		sb.note_byte(b, l);
		bytes_sent++;
	endtask

	task automatic send_region();
		for (int i = 0; i < region_q.size(); i++) send_byte(region_q[i], i == region_q.size() - 1);
		regions_sent++;
		region_q.delete();
	endtask

	// stop sending and let every owed result come out
	task automatic drain();
		@(negedge clk);
		byte_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [PDATA_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// random region: mostly a planted pattern copy, some broken copies, some noise
	task automatic random_region();
		int          len;
		int          n;
		int          pos;
		int          kind;
		int          j;
		logic [7:0]  m;
		logic [7:0]  p;
		len  = sb.eff_len();
		kind = $urandom_range(9);
		if ($urandom_range(9) == 0) n = $urandom_range(1, (len > 1) ? len - 1 : 1);
		else n = $urandom_range(len, 3 * len + 8);
		for (int i = 0; i < n; i++) region_q.push_back(8'($urandom));
		if (kind < 8 && n >= len) begin
			pos = $urandom_range(0, n - len);
			for (int k = 0; k < len; k++) begin
				m = sb.mask_bytes[8*k +: 8];
				p = sb.pattern_bytes[8*k +: 8];
				region_q[pos+k] = p | (8'($urandom) & ~m);
			end
			// broken copy: flip the lowest compared bit of one byte, if it has one
			if (kind >= 6) begin
				j = $urandom_range(0, len - 1);
				m = sb.mask_bytes[8*j +: 8];
				region_q[pos+j] = region_q[pos+j] ^ (m & (~m + 8'd1));
			end
		end
		send_region();
	endtask

	// random setting; mostly full-byte masks so that matches stay meaningful
	task automatic random_setting(input int phase);
		logic [LEN_W-1:0]  len;
		logic [PAT_W-1:0]  pat;
		logic [PAT_W-1:0]  msk;
		logic [ADDR_W-1:0] b;
		int                r;
		case (phase)
			0: len = LEN_W'(1);
			1: len = LEN_W'(16);
			2: len = LEN_W'(0);
			3: len = LEN_W'(31);
			default: len = LEN_W'($urandom_range(0, 31));
		endcase
		for (int k = 0; k < MAX_PATTERN; k++) begin
			r = $urandom_range(99);
			if (r < 60) msk[8*k +: 8] = 8'hff;
			else if (r < 80) msk[8*k +: 8] = 8'($urandom);
			else if (r < 90) msk[8*k +: 8] = 8'h00;
			else msk[8*k +: 8] = 8'h01 << $urandom_range(7);
		end
		pat = {rand64(), rand64()};
		if ($urandom_range(9) != 0) pat = pat & msk;
		r = $urandom_range(9);
		if (r == 0) b = '0;
		else if (r == 1) b = '1;
		else b = rand64();
		write_all(len, pat, msk, b);
	endtask

	initial begin
		logic [PAT_W-1:0] full_pat;
		int               phase;
		int               rand_start;
		arst_n       = 1'b0;
		byte_valid   = 1'b0;
		data_byte    = '0;
		last_byte    = 1'b0;
		result_ready = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		no_idle      = 1'b0;
		bytes_sent   = 0;
		regions_sent = 0;
		settings     = 1;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset setting: one zero byte under a zero mask matches anything
		region_q = '{8'h00};
		send_region();
		region_q = '{8'hff, 8'h55};
		send_region();
		drain();

		// length zero acts as one; base at all ones wraps the address
		write_all('0, PAT_W'(8'hab), PAT_W'(8'hff), '1);
		region_q = '{8'h12, 8'hab, 8'h01};
		send_region();
		region_q = '{8'haa};
		send_region();
		drain();

		// over-long length acts as the full window: match on the last byte, then a short region
		full_pat = {rand64(), rand64()};
		write_all(LEN_W'(31), full_pat, '1, 64'h0000_1000_0000_0000);
		for (int k = 0; k < MAX_PATTERN; k++) region_q.push_back(full_pat[8*k +: 8]);
		send_region();
		region_q = '{full_pat[7:0], full_pat[15:8], full_pat[23:16]};
		send_region();
		drain();

		// random phases
		rand_start = bytes_sent;
		phase      = 0;
		while (bytes_sent - rand_start < RANDOM_BYTES) begin
			random_setting(phase);
			repeat ($urandom_range(4, 10)) begin
				no_idle = (bytes_sent - rand_start >= 500) && (bytes_sent - rand_start < 800);
				if ($urandom_range(19) == 0) drain();
				random_region();
			end
			drain();
			phase++;
		end
		no_idle = 1'b0;
		drain();

		$display("scanned %0d bytes in %0d regions under %0d register settings",
			bytes_sent, regions_sent, settings);
		$display("checked %0d results, %0d of them matches", sb.checked, sb.match_count);
		if (sb.errors == 0) begin
			$display("masked_byte_signature_scan_unit_tb passed");
		end else begin
			$display("masked_byte_signature_scan_unit_tb failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#3_000_000;
		$display("masked_byte_signature_scan_unit_tb failed");
		$finish;
	end

endmodule
